// ----- design/rmad_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rmad_pkg;

    // Fixed widths of the result fields
    localparam int WORD_W  = 32;
    localparam int COST_W  = 39;
    localparam int COUNT_W = 7;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_DONE   = 2'd0,
        STATUS_FULL   = 2'd1,
        STATUS_ABSENT = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic {
        FSM_IDLE,
        FSM_SUM
    } fsm_t;

    // Shift commands broadcast to every cell
    typedef struct packed {
        logic ins_en;
        logic rem_en;
        logic is_remove;
    } cell_ctrl_t;

    // Compare results one cell reports
    typedef struct packed {
        logic mark;
        logic ge;
        logic eq;
        logic hit;
    } cell_stat_t;

endpackage

`default_nettype wire

// ----- design/rmad_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rmad_cell #(
    parameter int VW   = 32,
    parameter int CNTW = 7,
    parameter int IDX  = 0
) (
    input  wire logic                    aclk,
    input  wire rmad_pkg::cell_ctrl_t    ctrl,
    input  wire logic signed [VW-1:0]    x,
    input  wire logic signed [VW-1:0]    left_val,
    input  wire logic signed [VW-1:0]    right_val,
    input  wire logic                    left_mark,
    input  wire logic [CNTW-1:0]         count,
    input  wire logic [CNTW-1:0]         kk,
    input  wire logic [CNTW-1:0]         mk,
    output logic signed [VW-1:0]         val,
    output logic signed [VW-1:0]         med_part,
    output logic signed [VW-1:0]         nxt_part,
    output rmad_pkg::cell_stat_t         stat
);
    import rmad_pkg::*;

    localparam logic [CNTW-1:0] POS  = CNTW'(IDX);
    localparam logic [CNTW-1:0] POS1 = CNTW'(IDX + 1);

    logic signed [VW-1:0] val_reg;
    logic signed [VW-1:0] val_next;
    logic                 occ;
    logic                 mark;
    logic                 ge;

    // Compare the held word against the incoming value
    always_comb begin
        occ       = POS < count;
        mark      = !occ || (val_reg > x);
        ge        = occ && (val_reg >= x);
        stat.mark = mark;
        stat.ge   = ge;
        stat.eq   = occ && (val_reg == x);
        stat.hit  = (POS1 == kk) && (ctrl.is_remove ? ge : mark);
    end

    // Shift right to open a slot on insert, shift left to close one on remove
    always_comb begin
        val_next = val_reg;
        if (ctrl.ins_en) begin
            if (left_mark) begin
                val_next = left_val;
            end else if (mark) begin
                val_next = x;
            end
        end else if (ctrl.rem_en) begin
            if (ge) begin
                val_next = right_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    // Drive the median and next-above buses when selected
    always_comb begin
        val      = val_reg;
        med_part = (POS1 == mk) ? val_reg : '0;
        nxt_part = (POS == mk) ? val_reg : '0;
    end

endmodule

`default_nettype wire

// ----- design/rmad_chain.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rmad_chain #(
    parameter int CAPACITY = 64,
    parameter int VW       = 32,
    parameter int CNTW     = 7
) (
    input  wire logic                    aclk,
    input  wire rmad_pkg::cell_ctrl_t    ctrl,
    input  wire logic signed [VW-1:0]    x,
    input  wire logic [CNTW-1:0]         count,
    input  wire logic [CNTW-1:0]         kk,
    input  wire logic [CNTW-1:0]         mk,
    output logic                         any_eq,
    output logic                         any_hit,
    output logic signed [VW-1:0]         med,
    output logic signed [VW-1:0]         nxt
);
    import rmad_pkg::*;

    logic signed [VW-1:0] val_w   [CAPACITY];
    logic signed [VW-1:0] med_w   [CAPACITY];
    logic signed [VW-1:0] nxt_w   [CAPACITY];
    logic signed [VW-1:0] left_w  [CAPACITY];
    logic signed [VW-1:0] right_w [CAPACITY];
    logic                 lmark_w [CAPACITY];
    cell_stat_t           stat_w  [CAPACITY];

    // Row of sorted cells, each linked to both neighbors
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_first
            assign left_w[i]  = '0;
            assign lmark_w[i] = 1'b0;
        end else begin : g_mid
            assign left_w[i]  = val_w[i-1];
            assign lmark_w[i] = stat_w[i-1].mark;
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_w[i] = val_w[i];
        end else begin : g_inner
            assign right_w[i] = val_w[i+1];
        end

        rmad_cell #(
            .VW   (VW),
            .CNTW (CNTW),
            .IDX  (i)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .x         (x),
            .left_val  (left_w[i]),
            .right_val (right_w[i]),
            .left_mark (lmark_w[i]),
            .count     (count),
            .kk        (kk),
            .mk        (mk),
            .val       (val_w[i]),
            .med_part  (med_w[i]),
            .nxt_part  (nxt_w[i]),
            .stat      (stat_w[i])
        );
    end

    // Collect the one-hot buses and match flags
    always_comb begin
        any_eq  = 1'b0;
        any_hit = 1'b0;
        med     = '0;
        nxt     = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            any_eq  = any_eq | stat_w[i].eq;
            any_hit = any_hit | stat_w[i].hit;
            med     = med | med_w[i];
            nxt     = nxt | nxt_w[i];
        end
    end

endmodule

`default_nettype wire

// ----- design/running_median_abs_deviation_cost.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Running lower median and absolute-deviation cost over a multiset of up to
// CAPACITY signed values. Each input word inserts a value (s_op = 0) or removes
// one occurrence of it (s_op = 1); bits of s_value above VALUE_WIDTH are
// ignored. One result word follows every input word, giving the count, the
// lower median (element at sorted index ceil(n/2)-1) and the sum of
// |x - median|, with status 1 for an insert dropped on a full store and 2 for
// a remove of an absent value. Values live in a sorted chain of cells that
// shifts when a word is taken; the sum state then reads the median off the
// chain and updates the lower-half sum, and the result enters the output
// register while the next word is taken. No new word is taken while the
// sequencer is in the sum state. No clearing pass is needed after reset.
module running_median_abs_deviation_cost #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_op,
    input  wire logic signed [rmad_pkg::WORD_W-1:0] s_value,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [rmad_pkg::WORD_W-1:0]     m_median,
    output logic [rmad_pkg::COST_W-1:0]            m_cost,
    output logic [rmad_pkg::COUNT_W-1:0]           m_count,
    output logic                                   m_empty_res,
    output logic [1:0]                             m_status
);
    import rmad_pkg::*;

    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam int SW   = VALUE_WIDTH + $clog2(CAPACITY) + 2;

    function automatic logic [CNTW-1:0] half_up(input logic [CNTW-1:0] c);
        logic [CNTW:0] t;
        t = {1'b0, c} + (CNTW+1)'(1);
        return CNTW'(t >> 1);
    endfunction

    fsm_t                        state_reg, state_next;
    logic [CNTW-1:0]             count_reg, count_next;
    logic signed [SW-1:0]        total_reg, total_next;
    logic signed [SW-1:0]        lower_reg, lower_next;
    logic signed [VALUE_WIDTH-1:0] x_reg, med_reg, med_next;
    logic                        flag_reg, changed_reg, remove_reg;
    status_t                     status_reg, status_next;
    logic                        pend_reg, pend_next;
    logic                        m_valid_reg, m_valid_next;
    logic signed [WORD_W-1:0]    m_median_reg;
    logic [COST_W-1:0]           m_cost_reg;
    logic [COUNT_W-1:0]          m_count_reg;
    logic                        m_empty_reg;
    status_t                     m_status_reg;

    logic signed [VALUE_WIDTH-1:0] x;
    logic signed [VALUE_WIDTH-1:0] med;
    logic signed [VALUE_WIDTH-1:0] nxt;
    logic                        accept;
    logic                        out_free;
    logic                        out_load;
    logic                        full;
    logic                        ins_ok;
    logic                        rem_ok;
    logic                        any_eq;
    logic                        any_hit;
    logic [CNTW-1:0]             kk;
    logic [CNTW-1:0]             mk;
    cell_ctrl_t                  ctrl;
    logic signed [SW-1:0]        xs;
    logic signed [SW-1:0]        term_a;
    logic signed [SW-1:0]        term_b;
    logic signed [SW-1:0]        cost_full;

    assign x = s_value[VALUE_WIDTH-1:0];

    // Handshake: take a word when idle and the previous result has room
    assign out_free = !m_valid_reg || m_ready;
    assign out_load = (state_reg == FSM_IDLE) && pend_reg && out_free;
    assign s_ready  = (state_reg == FSM_IDLE) && (!pend_reg || out_free);
    assign accept   = s_valid && s_ready;

    // Decide whether the word changes the store
    assign full   = count_reg == CNTW'(CAPACITY);
    assign ins_ok = !s_op && !full;
    assign rem_ok = s_op && any_eq;
    assign kk     = s_op ? half_up(count_reg) : half_up(count_reg + CNTW'(1));
    assign mk     = half_up(count_reg);

    always_comb begin
        ctrl.is_remove = s_op;
        ctrl.ins_en    = accept && ins_ok;
        ctrl.rem_en    = accept && rem_ok;
    end

    rmad_chain #(
        .CAPACITY (CAPACITY),
        .VW       (VALUE_WIDTH),
        .CNTW     (CNTW)
    ) u_chain (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .x       (x),
        .count   (count_reg),
        .kk      (kk),
        .mk      (mk),
        .any_eq  (any_eq),
        .any_hit (any_hit),
        .med     (med),
        .nxt     (nxt)
    );

    // Lower-half correction terms from the new median and its upper neighbor
    always_comb begin
        xs     = SW'(x_reg);
        term_a = '0;
        term_b = '0;
        if (changed_reg) begin
            if (!remove_reg) begin
                if (!count_reg[0]) begin
                    term_a = flag_reg ? xs : '0;
                    term_b = flag_reg ? -SW'(nxt) : '0;
                end else begin
                    term_a = flag_reg ? xs : '0;
                    term_b = flag_reg ? '0 : SW'(med);
                end
            end else begin
                if (!count_reg[0]) begin
                    term_a = flag_reg ? -xs : '0;
                    term_b = flag_reg ? '0 : -SW'(nxt);
                end else begin
                    term_a = flag_reg ? -xs : '0;
                    term_b = flag_reg ? SW'(med) : '0;
                end
            end
        end
    end

    // Cost is total - 2 * lower, plus the median when the count is odd
    assign cost_full = total_reg - (lower_reg <<< 1)
                     + (count_reg[0] ? SW'(med_reg) : SW'(0));

    // Sequencer: shift cycle, then sum cycle
    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        total_next   = total_reg;
        lower_next   = lower_reg;
        med_next     = med_reg;
        status_next  = status_reg;
        pend_next    = pend_reg;
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (out_load) begin
            m_valid_next = 1'b1;
            pend_next    = 1'b0;
        end
        unique case (state_reg)
            FSM_IDLE: begin
                if (accept) begin
                    state_next = FSM_SUM;
                    priority if (ins_ok) begin
                        count_next  = count_reg + CNTW'(1);
                        total_next  = total_reg + SW'(x);
                        status_next = STATUS_DONE;
                    end else if (rem_ok) begin
                        count_next  = count_reg - CNTW'(1);
                        total_next  = total_reg - SW'(x);
                        status_next = STATUS_DONE;
                    end else if (s_op) begin
                        status_next = STATUS_ABSENT;
                    end else begin
                        status_next = STATUS_FULL;
                    end
                end
            end
            FSM_SUM: begin
                state_next = FSM_IDLE;
                lower_next = lower_reg + term_a + term_b;
                med_next   = med;
                pend_next  = 1'b1;
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            count_reg   <= '0;
            total_reg   <= '0;
            lower_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            total_reg   <= total_next;
            lower_reg   <= lower_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Capture per-word details and the result word
    always_ff @(posedge aclk) begin
        med_reg    <= med_next;
        status_reg <= status_next;
        if (accept) begin
            x_reg       <= x;
            flag_reg    <= any_hit;
            changed_reg <= ins_ok || rem_ok;
            remove_reg  <= s_op;
        end
        if (out_load) begin
            m_median_reg <= WORD_W'(med_reg);
            m_cost_reg   <= COST_W'(cost_full);
            m_count_reg  <= COUNT_W'(count_reg);
            m_empty_reg  <= count_reg == '0;
            m_status_reg <= status_reg;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_median    = m_median_reg;
    assign m_cost      = m_cost_reg;
    assign m_count     = m_count_reg;
    assign m_empty_res = m_empty_reg;
    assign m_status    = m_status_reg;

endmodule

`default_nettype wire

// ----- design/rmad_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rmad_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_median,
    input wire logic [38:0] m_cost,
    input wire logic [6:0]  m_count,
    input wire logic        m_empty_res,
    input wire logic [1:0]  m_status
);
    import rmad_pkg::*;

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_median) && $stable(m_cost))
        else $error("result word changed while stalled");

    // Empty flag tracks the count
    a_empty_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_empty_res == (m_count == 7'd0))
        else $error("empty flag disagrees with count");

    // Empty store reports zero median and zero cost
    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_empty_res |-> m_median == 32'd0 && m_cost == 39'd0)
        else $error("empty store with nonzero median or cost");

    // Busy for the sum cycle after taking a word
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken during sum cycle");

    // Status code stays within its defined set
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status == STATUS_DONE || m_status == STATUS_FULL ||
                    m_status == STATUS_ABSENT)
        else $error("undefined status code");

endmodule

bind running_median_abs_deviation_cost rmad_checker u_rmad_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_median    (m_median),
    .m_cost      (m_cost),
    .m_count     (m_count),
    .m_empty_res (m_empty_res),
    .m_status    (m_status)
);

`default_nettype wire

// ----- tb/sv/running_median_abs_deviation_cost_test.sv -----
`timescale 1ns / 1ps

module running_median_abs_deviation_cost_test;
    import rmad_pkg::*;

    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int DIRECTED_N  = 25;
    localparam int RANDOM_N    = 550;
    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 33;

    localparam bit OP_INSERT = 1'b0;
    localparam bit OP_REMOVE = 1'b1;

    localparam logic [WORD_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic [WORD_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

    // Value mixes for one stretch of random words
    localparam int MIX_WIDE    = 0;
    localparam int MIX_DUPS    = 1;
    localparam int MIX_EXTREME = 2;

    typedef struct {
        logic [WORD_W-1:0]  median;
        logic [COST_W-1:0]  cost;
        logic [COUNT_W-1:0] count;
        logic               empty_res;
        status_t            status;
    } median_report_t;

    // Sorted multiset model plus the queue of reports still owed by the block
    class median_cost_board;
        median_report_t expected_reports[$];
        longint         held_values[$];
        int             failures;
        int             reports_checked;
        int             full_drops;
        int             absent_removes;
        int             peak_count;

        // Apply one accepted word to the multiset and queue its report
        function void apply_word(bit op, logic [WORD_W-1:0] value);
            logic signed [WORD_W-1:0] sval;
            longint                   x;
            longint                   med;
            longint                   lower_sum;
            longint                   upper_sum;
            longint                   cost;
            logic [63:0]              cost_bits;
            logic [63:0]              med_bits;
            int                       pos;
            int                       n;
            int                       mid;
            median_report_t           rep;
            sval = value;
            x = longint'(sval);
            rep.status = STATUS_DONE;
            pos = 0;
            if (op == OP_INSERT) begin
                if (held_values.size() >= CAPACITY) begin
                    rep.status = STATUS_FULL;
                    full_drops++;
                end else begin
                    while (pos < held_values.size() && held_values[pos] <= x) pos++;
                    held_values.insert(pos, x);
                end
            end else begin
                while (pos < held_values.size() && held_values[pos] != x) pos++;
                if (pos >= held_values.size()) begin
                    rep.status = STATUS_ABSENT;
                    absent_removes++;
                end else begin
                    held_values.delete(pos);
                end
            end

            // Lower median and the cost from the two half sums
            n = held_values.size();
            med = 0;
            cost = 0;
            if (n > 0) begin
                mid = (n + 1) / 2 - 1;
                med = held_values[mid];
                lower_sum = 0;
                upper_sum = 0;
                for (int i = 0; i < n; i++) begin
                    if (i <= mid) lower_sum += held_values[i];
                    else upper_sum += held_values[i];
                end
                cost = (longint'(mid + 1) * med - lower_sum)
                     + (upper_sum - longint'(n - mid - 1) * med);
            end
            if (n > peak_count) peak_count = n;
            med_bits = med;
            cost_bits = cost;
            rep.median = med_bits[WORD_W-1:0];
            rep.cost = cost_bits[COST_W-1:0];
            rep.count = n[COUNT_W-1:0];
            rep.empty_res = (n == 0);
            expected_reports.insert(expected_reports.size(), rep);
        endfunction

        // Compare one result word against the oldest queued report
        function void check_result(logic [WORD_W-1:0] median, logic [COST_W-1:0] cost,
                                   logic [COUNT_W-1:0] count, logic empty_res,
                                   logic [1:0] status);
            median_report_t rep;
            reports_checked++;
            if (expected_reports.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("[%0t] result word with nothing outstanding: median %0d count %0d",
                             $realtime, $signed(median), count);
                return;
            end
            rep = expected_reports.pop_front();
            if (median !== rep.median || cost !== rep.cost || count !== rep.count ||
                empty_res !== rep.empty_res || status !== rep.status) begin
                failures++;
                if (failures <= 10) begin
                    $display("[%0t] result %0d mismatch (expected / actual):",
                             $realtime, reports_checked);
                    $display("    median %0d / %0d, cost %0d / %0d, count %0d / %0d",
                             $signed(rep.median), $signed(median), rep.cost, cost,
                             rep.count, count);
                    $display("    empty %0b / %0b, status %0d / %0d",
                             rep.empty_res, empty_res, rep.status, status);
                end
            end
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_op;
    logic signed [WORD_W-1:0]  s_value;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [WORD_W-1:0]  m_median;
    logic [COST_W-1:0]         m_cost;
    logic [COUNT_W-1:0]        m_count;
    logic                      m_empty_res;
    logic [1:0]                m_status;

    median_cost_board board;
    bit               calm;
    int               words_sent;
    int               inserts_sent;
    int               removes_sent;
    int               cycles;

    running_median_abs_deviation_cost #(
        .CAPACITY(CAPACITY),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_top (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_op(s_op),
        .s_value(s_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_median(m_median),
        .m_cost(m_cost),
        .m_count(m_count),
        .m_empty_res(m_empty_res),
        .m_status(m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Hold off the input side for a random number of cycles
    task automatic pause_sender();
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // Present one word and wait for it to be taken
    task automatic send_word(input bit op, input logic [WORD_W-1:0] value);
        pause_sender();
        @(negedge aclk);
        s_valid <= 1'b1;
        s_op <= op;
        s_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.apply_word(op, value);
        words_sent++;
        if (op == OP_INSERT) inserts_sent++;
        else removes_sent++;
    endtask

    // Wide mix draws random words half the time, else small or extreme values
    function automatic logic [WORD_W-1:0] pick_value(int mix);
        logic [WORD_W-1:0] v;
        int                kind;
        kind = mix;
        if (mix == MIX_WIDE && $urandom_range(0, 1) == 0)
            kind = $urandom_range(MIX_DUPS, MIX_EXTREME);
        case (kind)
            MIX_DUPS: begin
                v = $urandom_range(0, 8);
                v = v - 4;
            end
            MIX_EXTREME: begin
                case ($urandom_range(0, 5))
                    0: v = VAL_MIN;
                    1: v = VAL_MAX;
                    2: v = VAL_MIN + 1;
                    3: v = VAL_MAX - 1;
                    4: v = '0;
                    default: v = '1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Remove a value that is held, or a random one when the store is empty
    task automatic remove_held(input int mix);
        if (board.held_values.size() == 0)
            send_word(OP_REMOVE, pick_value(mix));
        else
            send_word(OP_REMOVE, WORD_W'(
                board.held_values[$urandom_range(0, board.held_values.size() - 1)]));
    endtask

    // Result side: random backpressure, check every accepted word
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            m_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                board.check_result(m_median, m_cost, m_count, m_empty_res, m_status);
        end
    end

    // Run limit
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycles, board.expected_reports.size());
        $display("** running_median_abs_deviation_cost: FAILED **");
        $finish;
    end

    initial begin
        int mix;
        int steps;
        board = new();
        calm = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op = OP_INSERT;
        s_value = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: empty remove, extremes, duplicates, absent remove, drain
        send_word(OP_REMOVE, 32'd5);
        send_word(OP_INSERT, VAL_MIN);
        send_word(OP_INSERT, VAL_MAX);
        send_word(OP_INSERT, '0);
        send_word(OP_INSERT, '1);
        send_word(OP_INSERT, '1);
        send_word(OP_INSERT, 32'd1);
        send_word(OP_REMOVE, '1);
        send_word(OP_REMOVE, 32'd12345);
        send_word(OP_REMOVE, VAL_MIN);
        send_word(OP_REMOVE, VAL_MAX);
        send_word(OP_REMOVE, '0);
        send_word(OP_REMOVE, '1);
        send_word(OP_REMOVE, '1);
        send_word(OP_REMOVE, 32'd1);
        send_word(OP_INSERT, VAL_MAX);
        send_word(OP_INSERT, VAL_MIN);
        send_word(OP_INSERT, VAL_MIN);
        send_word(OP_INSERT, VAL_MAX);
        send_word(OP_INSERT, VAL_MAX);
        send_word(OP_REMOVE, VAL_MAX);
        send_word(OP_REMOVE, VAL_MIN);
        send_word(OP_REMOVE, VAL_MAX);
        send_word(OP_REMOVE, VAL_MIN);
        send_word(OP_REMOVE, VAL_MAX);

        // Random: fill to capacity, drain to empty, and mixed stretches
        while (words_sent < DIRECTED_N + RANDOM_N) begin
            calm = (words_sent >= 250 && words_sent < 370);
            mix = $urandom_range(0, 2);
            case ($urandom_range(0, 3))
                0: begin
                    while (board.held_values.size() < CAPACITY) begin
                        if ($urandom_range(0, 9) == 0) remove_held(mix);
                        else send_word(OP_INSERT, pick_value(mix));
                    end
                    steps = $urandom_range(1, 4);
                    repeat (steps) send_word(OP_INSERT, pick_value(mix));
                end
                1: begin
                    while (board.held_values.size() > 0) begin
                        case ($urandom_range(0, 19))
                            0: send_word(OP_INSERT, pick_value(mix));
                            1, 2: send_word(OP_REMOVE, pick_value(mix));
                            default: remove_held(mix);
                        endcase
                    end
                    steps = $urandom_range(1, 2);
                    repeat (steps) send_word(OP_REMOVE, pick_value(mix));
                end
                default: begin
                    repeat (40) begin
                        steps = $urandom_range(0, 19);
                        if (steps < 11) send_word(OP_INSERT, pick_value(mix));
                        else if (steps < 18) remove_held(mix);
                        else send_word(OP_REMOVE, pick_value(mix));
                    end
                end
            endcase
        end
        calm = 1'b0;
        @(negedge aclk);
        s_valid <= 1'b0;

        // Drain outstanding results, then allow a few quiet cycles
        while (board.expected_reports.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("%0d words sent (%0d inserts, %0d removes), %0d results checked",
                 words_sent, inserts_sent, removes_sent, board.reports_checked);
        $display("%0d inserts dropped on a full store, %0d absent removes, peak count %0d",
                 board.full_drops, board.absent_removes, board.peak_count);
        if (board.failures == 0 && board.expected_reports.size() == 0) begin
            $display("** running_median_abs_deviation_cost: PASSED **");
        end else begin
            $display("%0d failures", board.failures);
            $display("** running_median_abs_deviation_cost: FAILED **");
        end
        $finish;
    end

endmodule

// ----- files.f -----
design/rmad_pkg.sv
design/rmad_cell.sv
design/rmad_chain.sv
design/running_median_abs_deviation_cost.sv
design/rmad_checker.sv
tb/sv/running_median_abs_deviation_cost_test.sv
